FILE: sv/hpdc_pkg.sv
package hpdc_pkg;

  typedef enum logic [4:0] {
    ST_START       = 5'd0,
    ST_COOL_WAIT   = 5'd1,
    ST_COOL_VALVE  = 5'd2,
    ST_COOL_COMP   = 5'd3,
    ST_COOL_RUN    = 5'd4,
    ST_COIL_DEF    = 5'd5,
    ST_COIL_DRIP   = 5'd6,
    ST_COIL_END    = 5'd7,
    ST_HEAT_WAIT   = 5'd8,
    ST_HEAT_COMP   = 5'd9,
    ST_HEAT_RUN    = 5'd10,
    ST_DEF_SELECT  = 5'd11,
    ST_NAT_DEF     = 5'd12,
    ST_NAT_DRIP    = 5'd13,
    ST_NAT_END     = 5'd14,
    ST_REV_VALVE   = 5'd15,
    ST_REV_COMPDLY = 5'd16,
    ST_REV_DEF     = 5'd17,
    ST_REV_DRIP    = 5'd18,
    ST_REV_END     = 5'd19,
    ST_HW_WAIT     = 5'd20,
    ST_HW_VALVE    = 5'd21,
    ST_HW_COMP     = 5'd22,
    ST_HW_RUN      = 5'd23,
    ST_UNUSED_24   = 5'd24,
    ST_UNUSED_25   = 5'd25,
    ST_UNUSED_26   = 5'd26,
    ST_UNUSED_27   = 5'd27,
    ST_UNUSED_28   = 5'd28,
    ST_UNUSED_29   = 5'd29,
    ST_UNUSED_30   = 5'd30,
    ST_UNUSED_31   = 5'd31
  } seq_state_t;

  typedef enum logic [2:0] {
    REG_CHANGEOVER = 3'd0,
    REG_HEATWAVE   = 3'd1,
    REG_LOCKOUT    = 3'd2,
    REG_CDEF_START = 3'd3,
    REG_CDEF_END   = 3'd4,
    REG_ELEC_SEL   = 3'd5,
    REG_HDEF_END   = 3'd6,
    REG_HW_DELTA   = 3'd7
  } reg_idx_t;

  localparam int unsigned AddrW = 5;
  localparam int unsigned RuntimeW = 48;

  localparam logic [31:0] T_IDLE      = 32'd200000;
  localparam logic [31:0] T_VALVE     = 32'd1000000;
  localparam logic [31:0] T_COMP      = 32'd2000000;
  localparam logic [31:0] T_DEF_VALVE = 32'd1500000;
  localparam logic [31:0] T_DEF_COMP  = 32'd1500000;
  localparam logic [31:0] T_DEF_ELEC  = 32'd5000000;
  localparam logic [31:0] T_HEAT_RUN  = 32'd20000000;
  localparam logic [31:0] T_DEF_NAT   = 32'd10000000;
  localparam logic [31:0] T_DRIP      = 32'd5000000;
  localparam logic [31:0] T_DRIP_END  = 32'd3000000;

  localparam logic signed [11:0] IFAN_START_TEMP = 12'sd560;
  localparam logic signed [11:0] OFAN_COOL_HIGH  = 12'sd320;
  localparam logic signed [11:0] IFAN_SPEED_TEMP = 12'sd368;
  localparam logic signed [11:0] OFAN_HEAT_HIGH  = 12'sd80;

  typedef struct packed {
    logic signed [11:0] changeover;
    logic signed [11:0] heatwave;
    logic signed [11:0] lockout;
    logic signed [11:0] cdef_start;
    logic signed [11:0] cdef_end;
    logic signed [11:0] elec_sel;
    logic signed [11:0] hdef_end;
    logic [10:0]        hw_delta;
  } cfg_regs_t;

  typedef struct packed {
    logic               [31:0] now_us;
    logic signed        [11:0] oair;
    logic signed        [11:0] unit;
    logic signed        [11:0] ocoil;
    logic signed        [11:0] iret;
    logic signed        [11:0] icoil;
    logic                      call;
  } tick_t;

  // Relay bits: season, comp, valve, ofan, ofan_hi, ifan, ifan_hi from bit 0.
  typedef struct packed {
    logic [4:0]          state;
    logic [6:0]          relays;
    logic [RuntimeW-1:0] runtime;
  } result_t;

endpackage

FILE: sv/hpdc_cfg_regs.sv
module hpdc_cfg_regs
  import hpdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output cfg_regs_t        cfg
);

  cfg_regs_t cfg_r;
  logic      wr_en;
  reg_idx_t  idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[4:2]);
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.changeover <= 12'sd216;
      cfg_r.heatwave   <= 12'sd480;
      cfg_r.lockout    <= 12'sd176;
      cfg_r.cdef_start <= 12'sd64;
      cfg_r.cdef_end   <= 12'sd240;
      cfg_r.elec_sel   <= 12'sd80;
      cfg_r.hdef_end   <= 12'sd200;
      cfg_r.hw_delta   <= 11'd96;
    end else if (wr_en) begin
      unique case (idx)
        REG_CHANGEOVER: cfg_r.changeover <= pwdata[11:0];
        REG_HEATWAVE:   cfg_r.heatwave   <= pwdata[11:0];
        REG_LOCKOUT:    cfg_r.lockout    <= pwdata[11:0];
        REG_CDEF_START: cfg_r.cdef_start <= pwdata[11:0];
        REG_CDEF_END:   cfg_r.cdef_end   <= pwdata[11:0];
        REG_ELEC_SEL:   cfg_r.elec_sel   <= pwdata[11:0];
        REG_HDEF_END:   cfg_r.hdef_end   <= pwdata[11:0];
        REG_HW_DELTA:   cfg_r.hw_delta   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_CHANGEOVER: prdata = {{20{cfg_r.changeover[11]}}, cfg_r.changeover};
        REG_HEATWAVE:   prdata = {{20{cfg_r.heatwave[11]}}, cfg_r.heatwave};
        REG_LOCKOUT:    prdata = {{20{cfg_r.lockout[11]}}, cfg_r.lockout};
        REG_CDEF_START: prdata = {{20{cfg_r.cdef_start[11]}}, cfg_r.cdef_start};
        REG_CDEF_END:   prdata = {{20{cfg_r.cdef_end[11]}}, cfg_r.cdef_end};
        REG_ELEC_SEL:   prdata = {{20{cfg_r.elec_sel[11]}}, cfg_r.elec_sel};
        REG_HDEF_END:   prdata = {{20{cfg_r.hdef_end[11]}}, cfg_r.hdef_end};
        REG_HW_DELTA:   prdata = {21'd0, cfg_r.hw_delta};
        default:        prdata = '0;
      endcase
    end
  end

endmodule

FILE: sv/hpdc_core.sv
module hpdc_core
  import hpdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  tick_t     tick,
  input  cfg_regs_t cfg,
  output result_t   res
);

  seq_state_t          state_r, state_nxt;
  logic [31:0]         phase_r, phase_nxt;
  logic [31:0]         run_r, run_nxt;
  logic [31:0]         idle_r, idle_nxt;
  logic [6:0]          rel_r, rel_nxt;
  logic [RuntimeW-1:0] acc_r, acc_nxt;

  logic [31:0]         el, run_el, idle_el;
  logic [RuntimeW:0]   acc_sum;
  logic [RuntimeW-1:0] acc_sat;
  logic                ch, ca;
  logic signed [12:0]  hw_lim;

  localparam int unsigned R_SEASON = 0;
  localparam int unsigned R_COMP   = 1;
  localparam int unsigned R_VALVE  = 2;
  localparam int unsigned R_OFAN   = 3;
  localparam int unsigned R_OFANHI = 4;
  localparam int unsigned R_IFAN   = 5;
  localparam int unsigned R_IFANHI = 6;

  assign el      = tick.now_us - phase_r;
  assign run_el  = tick.now_us - run_r;
  assign idle_el = tick.now_us - idle_r;
  assign acc_sum = {1'b0, acc_r} + {{(RuntimeW - 31){1'b0}}, run_el};
  assign acc_sat = acc_sum[RuntimeW] ? {RuntimeW{1'b1}} : acc_sum[RuntimeW-1:0];
  assign ch      = tick.call && (tick.oair <= cfg.lockout);
  assign hw_lim  = 13'(tick.oair) - $signed({2'b00, cfg.hw_delta});
  assign ca      = 13'(tick.iret) > hw_lim;

  always_comb begin
    seq_state_t nx;
    nx        = state_r;
    rel_nxt   = rel_r;
    run_nxt   = run_r;
    acc_nxt   = acc_r;
    unique case (state_r)
      ST_START: begin
        if (tick.oair < cfg.changeover) begin
          rel_nxt[R_SEASON] = 1'b0; nx = ST_HEAT_WAIT;
        end else if (tick.oair <= cfg.heatwave) begin
          rel_nxt[R_SEASON] = 1'b1; nx = ST_COOL_WAIT;
        end else begin
          nx = ST_HW_WAIT;
        end
      end
      ST_COOL_WAIT, ST_HEAT_WAIT, ST_HW_WAIT: begin
        if ((state_r == ST_COOL_WAIT && tick.call) || (state_r == ST_HEAT_WAIT && ch)
            || (state_r == ST_HW_WAIT && ca)) begin
          nx = seq_state_t'(state_r + 5'd1);
        end else begin
          if (idle_el >= T_IDLE) nx = ST_START;
          rel_nxt = rel_r & 7'h01;
        end
      end
      ST_COOL_VALVE, ST_COOL_COMP: begin
        if (!tick.call) nx = ST_COOL_WAIT;
        else if (state_r == ST_COOL_VALVE && el >= T_VALVE) begin
          rel_nxt[R_VALVE] = 1'b1; nx = ST_COOL_COMP;
        end else if (state_r == ST_COOL_COMP && el >= T_COMP) begin
          run_nxt = tick.now_us; nx = ST_COOL_RUN;
        end else begin
          rel_nxt[R_OFAN]   = 1'b1;
          rel_nxt[R_OFANHI] = tick.unit > OFAN_COOL_HIGH;
          rel_nxt[R_IFAN]   = 1'b1;
          rel_nxt[R_IFANHI] = tick.iret >= IFAN_SPEED_TEMP;
        end
      end
      ST_COOL_RUN: begin
        if (!tick.call) begin
          acc_nxt = acc_sat; rel_nxt = rel_r & 7'h01; nx = ST_COOL_WAIT;
        end else if (tick.icoil <= cfg.cdef_start) begin
          acc_nxt = acc_sat; nx = ST_COIL_DEF;
        end else begin
          rel_nxt[R_OFAN]   = 1'b1;
          rel_nxt[R_OFANHI] = tick.unit > OFAN_COOL_HIGH;
          rel_nxt[R_IFAN]   = 1'b1;
          rel_nxt[R_IFANHI] = tick.iret >= IFAN_SPEED_TEMP;
          rel_nxt[R_COMP]   = 1'b1;
        end
      end
      ST_COIL_DEF: begin
        if (tick.icoil >= cfg.cdef_end) nx = ST_COIL_DRIP;
        else rel_nxt = rel_r & 7'h01;
      end
      ST_COIL_DRIP: begin
        if (el >= T_DRIP) nx = ST_COIL_END;
        else begin
          rel_nxt[R_IFAN] = 1'b1; rel_nxt[R_IFANHI] = 1'b0;
        end
      end
      ST_COIL_END, ST_NAT_END: begin
        if (el >= T_DRIP_END) nx = ST_START;
        else rel_nxt = rel_r & 7'h01;
      end
      ST_HEAT_COMP: begin
        if (!ch) nx = ST_HEAT_WAIT;
        else if (el >= T_COMP) begin
          run_nxt = tick.now_us; nx = ST_HEAT_RUN;
        end else begin
          rel_nxt[R_OFAN] = 1'b1; rel_nxt[R_OFANHI] = tick.unit < OFAN_HEAT_HIGH;
        end
      end
      ST_HEAT_RUN: begin
        if (!ch) begin
          acc_nxt = acc_sat; nx = ST_HEAT_WAIT;
        end else if (el >= T_HEAT_RUN) begin
          acc_nxt = acc_sat; nx = ST_DEF_SELECT;
        end else begin
          rel_nxt[R_COMP] = 1'b1;
          if (tick.icoil >= IFAN_START_TEMP) rel_nxt[R_IFAN] = 1'b1;
          rel_nxt[R_IFANHI] = !(tick.iret > IFAN_SPEED_TEMP);
          rel_nxt[R_OFAN]   = 1'b1;
          rel_nxt[R_OFANHI] = tick.unit < OFAN_HEAT_HIGH;
        end
      end
      ST_DEF_SELECT: begin
        nx = (tick.unit <= cfg.elec_sel) ? ST_REV_VALVE : ST_NAT_DEF;
      end
      ST_NAT_DEF: begin
        if (el >= T_DEF_NAT) nx = ST_NAT_DRIP;
        else rel_nxt = rel_r & 7'h01;
      end
      ST_NAT_DRIP, ST_REV_END: begin
        if (state_r == ST_NAT_DRIP && el >= T_DRIP) nx = ST_NAT_END;
        else if (state_r == ST_REV_END && el >= T_DRIP_END) begin
          rel_nxt = rel_r & 7'h01; nx = ST_START;
        end else begin
          rel_nxt[R_OFAN] = 1'b1; rel_nxt[R_OFANHI] = 1'b1;
        end
      end
      ST_REV_VALVE: begin
        if (el >= T_DEF_VALVE) nx = ST_REV_COMPDLY;
        else rel_nxt = rel_r & 7'h01;
      end
      ST_REV_COMPDLY: begin
        if (el >= T_DEF_COMP) nx = ST_REV_DEF;
        else rel_nxt[R_VALVE] = 1'b1;
      end
      ST_REV_DEF: begin
        if (tick.ocoil >= cfg.hdef_end || el >= T_DEF_ELEC) nx = ST_REV_DRIP;
        else rel_nxt[R_COMP] = 1'b1;
      end
      ST_REV_DRIP: begin
        if (el >= T_DRIP) nx = ST_REV_END;
        else rel_nxt = rel_r & 7'h01;
      end
      ST_HW_VALVE, ST_HW_COMP: begin
        if (!ca) nx = ST_HW_WAIT;
        else if (state_r == ST_HW_VALVE && el >= T_VALVE) begin
          rel_nxt[R_VALVE] = 1'b1; nx = ST_HW_COMP;
        end else if (state_r == ST_HW_COMP && el >= T_COMP) begin
          run_nxt = tick.now_us; nx = ST_HW_RUN;
        end else begin
          rel_nxt[R_OFAN] = 1'b1; rel_nxt[R_OFANHI] = 1'b1;
          rel_nxt[R_IFAN] = (state_r == ST_HW_COMP); rel_nxt[R_IFANHI] = 1'b1;
        end
      end
      ST_HW_RUN: begin
        if (!ca) begin
          acc_nxt = acc_sat; nx = ST_HW_WAIT;
        end else if (tick.icoil <= cfg.cdef_start) begin
          acc_nxt = acc_sat; nx = ST_COIL_DEF;
        end else begin
          rel_nxt[R_COMP] = 1'b1;
        end
      end
      default: nx = ST_START;
    endcase
    state_nxt = nx;
    phase_nxt = phase_r;
    idle_nxt  = idle_r;
    if (nx != state_r) begin
      phase_nxt = tick.now_us;
      if (nx == ST_COOL_WAIT || nx == ST_HEAT_WAIT || nx == ST_HW_WAIT) begin
        idle_nxt = tick.now_us;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      phase_r <= '0;
      run_r   <= '0;
      idle_r  <= '0;
      rel_r   <= '0;
      acc_r   <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      run_r   <= run_nxt;
      idle_r  <= idle_nxt;
      rel_r   <= rel_nxt;
      acc_r   <= acc_nxt;
    end
  end

  assign res.state   = state_nxt;
  assign res.relays  = rel_nxt;
  assign res.runtime = acc_nxt;

endmodule

FILE: sv/heat_pump_mode_defrost_controller_top.sv
// Channel  | Direction | Payload
// in_      | slave     | tdata: now_us, temps, thermostat_call (104 bits)
// out_     | master    | tdata: control_state, relays, filter_runtime_us (64 bits)
// cfg_     | APB slave | eight 12/11-bit registers at 4*i
//
// Each item is registered, then evaluated by the combinational sequencer logic
// whose result lands in an output register; one item per cycle is sustained
// while the output is not stalled, and the output register presents each result.
// Reset is synchronous, active low, and restores all but the item data registers to defaults.
// A stalled output holds its item; the input register refills as soon as the
// output register drains, so back-to-back traffic sees no bubbles.
module heat_pump_mode_defrost_controller_top
  import hpdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // now_us[31:0], temp_outdoor_air[43:32], temp_outdoor_unit[55:44],
  // temp_outdoor_coil[67:56], temp_indoor_return[79:68],
  // temp_indoor_coil[91:80], thermostat_call[92], zero fill to 104.
  input  logic [103:0]     in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // control_state[4:0], season_relay[5], compressor_on[6],
  // reversing_valve_on[7], outdoor_fan_on[8], outdoor_fan_high[9],
  // indoor_fan_on[10], indoor_fan_high[11], filter_runtime_us[59:12],
  // zero fill to 64.
  output logic [63:0]      out_tdata,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_regs_t cfg;
  tick_t     tick_r;
  logic      in_vld_r, out_vld_r, step;
  result_t   res, res_r;

  assign cfg_pready = 1'b1;

  hpdc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // The evaluated item moves into the output register when it is free.
  assign step      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) in_vld_r <= in_tvalid;
      if (step) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      tick_r.now_us <= in_tdata[31:0];
      tick_r.oair   <= in_tdata[43:32];
      tick_r.unit   <= in_tdata[55:44];
      tick_r.ocoil  <= in_tdata[67:56];
      tick_r.iret   <= in_tdata[79:68];
      tick_r.icoil  <= in_tdata[91:80];
      tick_r.call   <= in_tdata[92];
    end
    if (step) res_r <= res;
  end

  hpdc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .tick  (tick_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, res_r.runtime, res_r.relays, res_r.state};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output item changed while stalled");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_tvalid)
    else $error("evaluated item not presented");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_tready)
    else $error("empty input stage refused an item");

endmodule

FILE: bench/heat_pump_mode_defrost_controller_top_test.sv
module heat_pump_mode_defrost_controller_top_test
  import hpdc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // One control tick as the sender packs it onto in_tdata.
  typedef struct {
    logic [31:0]        now_us;
    logic signed [11:0] oair;
    logic signed [11:0] unit;
    logic signed [11:0] ocoil;
    logic signed [11:0] iret;
    logic signed [11:0] icoil;
    logic               call;
  } tick_s;

  // Expected sequencer outcome of one tick.
  typedef struct {
    logic [4:0]  state;
    logic [6:0]  relays;
    logic [47:0] runtime;
  } outcome_s;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [47:0] RUNTIME_SAT = 48'hFFFF_FFFF_FFFF;

  // Relay bit positions, season relay at bit 0.
  localparam int RL_SEASON = 0;
  localparam int RL_COMP   = 1;
  localparam int RL_VALVE  = 2;
  localparam int RL_OFAN   = 3;
  localparam int RL_OFANHI = 4;
  localparam int RL_IFAN   = 5;
  localparam int RL_IFANHI = 6;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [AddrW-1:0] cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  heat_pump_mode_defrost_controller_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The predictor keeps its own copy of the configuration and the sequencer.
  logic signed [11:0] thr_changeover, thr_heatwave, thr_lockout, thr_cdef_start;
  logic signed [11:0] thr_cdef_end, thr_elec_sel, thr_hdef_end;
  logic [10:0]        thr_hw_delta;
  seq_state_t         pred_state;
  logic [31:0]        pred_phase_t, pred_run_t, pred_idle_t;
  logic [6:0]         pred_relays;
  logic [47:0]        pred_runtime;

  tick_s    pending_ticks[$];
  outcome_s expected_outcomes[$];
  int       error_count;
  int       quiet_cycles;

  // Simulated clock of the tick stream, in microseconds; it may wrap.
  logic [31:0] clock_us;

  // Knobs set by the stimulus process.
  logic        allow_idle;
  logic        long_hold;

  // Set at each rising edge at which an input item was accepted.
  bit          in_taken;

  task automatic restore_defaults();
    thr_changeover = 12'sd216;
    thr_heatwave   = 12'sd480;
    thr_lockout    = 12'sd176;
    thr_cdef_start = 12'sd64;
    thr_cdef_end   = 12'sd240;
    thr_elec_sel   = 12'sd80;
    thr_hdef_end   = 12'sd200;
    thr_hw_delta   = 11'd96;
    pred_state     = ST_START;
    pred_phase_t   = '0;
    pred_run_t     = '0;
    pred_idle_t    = '0;
    pred_relays    = '0;
    pred_runtime   = '0;
  endtask

  function automatic void move_to(seq_state_t nxt, logic [31:0] now);
    if (nxt != pred_state) begin
      pred_phase_t = now;
      if (nxt == ST_COOL_WAIT || nxt == ST_HEAT_WAIT || nxt == ST_HW_WAIT) begin
        pred_idle_t = now;
      end
    end
    pred_state = nxt;
  endfunction

  function automatic void drop_relays();
    pred_relays = pred_relays & 7'b0000001;
  endfunction

  function automatic void add_runtime(logic [31:0] now);
    logic [48:0] sum;
    sum = {1'b0, pred_runtime} + {17'd0, now - pred_run_t};
    pred_runtime = sum[48] ? RUNTIME_SAT : sum[47:0];
  endfunction

  function automatic void cool_fans(logic signed [11:0] unit, logic signed [11:0] iret);
    pred_relays[RL_OFAN]   = 1'b1;
    pred_relays[RL_OFANHI] = unit > OFAN_COOL_HIGH;
    pred_relays[RL_IFAN]   = 1'b1;
    pred_relays[RL_IFANHI] = iret >= IFAN_SPEED_TEMP;
  endfunction

  function automatic void heat_out_fan(logic signed [11:0] unit);
    pred_relays[RL_OFAN]   = 1'b1;
    pred_relays[RL_OFANHI] = unit < OFAN_HEAT_HIGH;
  endfunction

  function automatic void all_fans_on();
    pred_relays[RL_OFAN]   = 1'b1;
    pred_relays[RL_OFANHI] = 1'b1;
    pred_relays[RL_IFAN]   = 1'b1;
    pred_relays[RL_IFANHI] = 1'b1;
  endfunction

  function automatic void idle_in_wait(logic [31:0] now);
    if (now - pred_idle_t >= T_IDLE) move_to(ST_START, now);
    drop_relays();
  endfunction

  // Advances the sequencer by one tick and returns what the block should emit.
  function automatic outcome_s sequence_tick(tick_s t);
    outcome_s    o;
    logic        heat_call, hw_call;
    logic [31:0] el;
    logic signed [13:0] hw_floor;
    hw_floor  = 14'(t.oair) - 14'(signed'({1'b0, thr_hw_delta}));
    heat_call = t.call && (t.oair <= thr_lockout);
    hw_call   = 14'(t.iret) > hw_floor;
    el        = t.now_us - pred_phase_t;
    case (pred_state)
      ST_START: begin
        if (t.oair < thr_changeover) begin
          pred_relays[RL_SEASON] = 1'b0;
          move_to(ST_HEAT_WAIT, t.now_us);
        end else if (t.oair <= thr_heatwave) begin
          pred_relays[RL_SEASON] = 1'b1;
          move_to(ST_COOL_WAIT, t.now_us);
        end else begin
          move_to(ST_HW_WAIT, t.now_us);
        end
      end
      ST_COOL_WAIT: begin
        if (t.call) move_to(ST_COOL_VALVE, t.now_us);
        else idle_in_wait(t.now_us);
      end
      ST_COOL_VALVE: begin
        if (!t.call) move_to(ST_COOL_WAIT, t.now_us);
        else if (el >= T_VALVE) begin
          pred_relays[RL_VALVE] = 1'b1;
          move_to(ST_COOL_COMP, t.now_us);
        end else cool_fans(t.unit, t.iret);
      end
      ST_COOL_COMP: begin
        if (!t.call) move_to(ST_COOL_WAIT, t.now_us);
        else if (el >= T_COMP) begin
          pred_run_t = t.now_us;
          move_to(ST_COOL_RUN, t.now_us);
        end else cool_fans(t.unit, t.iret);
      end
      ST_COOL_RUN: begin
        if (!t.call) begin
          add_runtime(t.now_us);
          drop_relays();
          move_to(ST_COOL_WAIT, t.now_us);
        end else if (t.icoil <= thr_cdef_start) begin
          add_runtime(t.now_us);
          move_to(ST_COIL_DEF, t.now_us);
        end else begin
          cool_fans(t.unit, t.iret);
          pred_relays[RL_COMP] = 1'b1;
        end
      end
      ST_COIL_DEF: begin
        if (t.icoil >= thr_cdef_end) move_to(ST_COIL_DRIP, t.now_us);
        else drop_relays();
      end
      ST_COIL_DRIP: begin
        if (el >= T_DRIP) move_to(ST_COIL_END, t.now_us);
        else begin
          pred_relays[RL_IFAN]   = 1'b1;
          pred_relays[RL_IFANHI] = 1'b0;
        end
      end
      ST_COIL_END: begin
        if (el >= T_DRIP_END) move_to(ST_START, t.now_us);
        else drop_relays();
      end
      ST_HEAT_WAIT: begin
        if (heat_call) move_to(ST_HEAT_COMP, t.now_us);
        else idle_in_wait(t.now_us);
      end
      ST_HEAT_COMP: begin
        if (!heat_call) move_to(ST_HEAT_WAIT, t.now_us);
        else if (el >= T_COMP) begin
          pred_run_t = t.now_us;
          move_to(ST_HEAT_RUN, t.now_us);
        end else heat_out_fan(t.unit);
      end
      ST_HEAT_RUN: begin
        if (!heat_call) begin
          add_runtime(t.now_us);
          move_to(ST_HEAT_WAIT, t.now_us);
        end else if (el >= T_HEAT_RUN) begin
          add_runtime(t.now_us);
          move_to(ST_DEF_SELECT, t.now_us);
        end else begin
          pred_relays[RL_COMP] = 1'b1;
          if (t.icoil >= IFAN_START_TEMP) pred_relays[RL_IFAN] = 1'b1;
          pred_relays[RL_IFANHI] = !(t.iret > IFAN_SPEED_TEMP);
          heat_out_fan(t.unit);
        end
      end
      ST_DEF_SELECT: begin
        if (t.unit <= thr_elec_sel) move_to(ST_REV_VALVE, t.now_us);
        else move_to(ST_NAT_DEF, t.now_us);
      end
      ST_NAT_DEF: begin
        if (el >= T_DEF_NAT) move_to(ST_NAT_DRIP, t.now_us);
        else drop_relays();
      end
      ST_NAT_DRIP: begin
        if (el >= T_DRIP) move_to(ST_NAT_END, t.now_us);
        else begin
          pred_relays[RL_OFAN]   = 1'b1;
          pred_relays[RL_OFANHI] = 1'b1;
        end
      end
      ST_NAT_END: begin
        if (el >= T_DRIP_END) move_to(ST_START, t.now_us);
        else drop_relays();
      end
      ST_REV_VALVE: begin
        if (el >= T_DEF_VALVE) move_to(ST_REV_COMPDLY, t.now_us);
        else drop_relays();
      end
      ST_REV_COMPDLY: begin
        if (el >= T_DEF_COMP) move_to(ST_REV_DEF, t.now_us);
        else pred_relays[RL_VALVE] = 1'b1;
      end
      ST_REV_DEF: begin
        if (t.ocoil >= thr_hdef_end || el >= T_DEF_ELEC) move_to(ST_REV_DRIP, t.now_us);
        else pred_relays[RL_COMP] = 1'b1;
      end
      ST_REV_DRIP: begin
        if (el >= T_DRIP) move_to(ST_REV_END, t.now_us);
        else drop_relays();
      end
      ST_REV_END: begin
        if (el >= T_DRIP_END) begin
          drop_relays();
          move_to(ST_START, t.now_us);
        end else begin
          pred_relays[RL_OFAN]   = 1'b1;
          pred_relays[RL_OFANHI] = 1'b1;
        end
      end
      ST_HW_WAIT: begin
        if (hw_call) move_to(ST_HW_VALVE, t.now_us);
        else idle_in_wait(t.now_us);
      end
      ST_HW_VALVE: begin
        if (!hw_call) move_to(ST_HW_WAIT, t.now_us);
        else if (el >= T_VALVE) begin
          pred_relays[RL_VALVE] = 1'b1;
          move_to(ST_HW_COMP, t.now_us);
        end else begin
          all_fans_on();
          pred_relays[RL_IFAN] = 1'b0;
        end
      end
      ST_HW_COMP: begin
        if (!hw_call) move_to(ST_HW_WAIT, t.now_us);
        else if (el >= T_COMP) begin
          pred_run_t = t.now_us;
          move_to(ST_HW_RUN, t.now_us);
        end else all_fans_on();
      end
      ST_HW_RUN: begin
        if (!hw_call) begin
          add_runtime(t.now_us);
          move_to(ST_HW_WAIT, t.now_us);
        end else if (t.icoil <= thr_cdef_start) begin
          add_runtime(t.now_us);
          move_to(ST_COIL_DEF, t.now_us);
        end else pred_relays[RL_COMP] = 1'b1;
      end
      default: move_to(ST_START, t.now_us);
    endcase
    o.state   = pred_state;
    o.relays  = pred_relays;
    o.runtime = pred_runtime;
    return o;
  endfunction

  function automatic tick_s in_tick_view();
    tick_s t;
    t.now_us = in_tdata[31:0];
    t.oair   = in_tdata[43:32];
    t.unit   = in_tdata[55:44];
    t.ocoil  = in_tdata[67:56];
    t.iret   = in_tdata[79:68];
    t.icoil  = in_tdata[91:80];
    t.call   = in_tdata[92];
    return t;
  endfunction

  // The predictor runs on each accepted input item, at the rising edge, and
  // notes the acceptance for the driver.
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      expected_outcomes.insert(expected_outcomes.size(), sequence_tick(in_tick_view()));
    end
  end

  // Driver: offers queued ticks, with random gaps while idling is allowed.
  int tx_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_taken) begin
        void'(pending_ticks.pop_front());
      end
      if (in_tvalid && !in_taken) begin
        // Hold the item until it is taken.
      end else if (tx_gap > 0) begin
        tx_gap = tx_gap - 1;
        in_tvalid <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(0, 14);
        in_tvalid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {11'd0, pending_ticks[0].call, pending_ticks[0].icoil,
                      pending_ticks[0].iret, pending_ticks[0].ocoil,
                      pending_ticks[0].unit, pending_ticks[0].oair,
                      pending_ticks[0].now_us};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: random stalls, plus one long hold-off that the
  // receiver counts itself once asked for.
  int rx_gap;
  int hold_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap = 0;
      hold_left = 0;
    end else if (long_hold) begin
      long_hold = 1'b0;
      hold_left = 199;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      out_tready <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: compares every accepted result field by field.
  always @(posedge clk) begin
    outcome_s e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_tdata);
        error_count++;
      end else begin
        e = expected_outcomes.pop_front();
        if (out_tdata[4:0] !== e.state) begin
          $display("%0t: control_state expected %0d actual %0d",
                   $realtime, e.state, out_tdata[4:0]);
          error_count++;
        end
        if (out_tdata[11:5] !== e.relays) begin
          $display("%0t: relays expected %b actual %b", $realtime, e.relays, out_tdata[11:5]);
          error_count++;
        end
        if (out_tdata[59:12] !== e.runtime) begin
          $display("%0t: filter_runtime_us expected %0d actual %0d",
                   $realtime, e.runtime, out_tdata[59:12]);
          error_count++;
        end
        if (out_tdata[63:60] !== 4'd0) begin
          $display("%0t: fill bits expected 0 actual %h", $realtime, out_tdata[63:60]);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item while work is outstanding.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (pending_ticks.size() != 0 || expected_outcomes.size() != 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // APB register write; the predictor's copy changes at the same edge.
  task automatic write_threshold(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= AddrW'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_CHANGEOVER: thr_changeover = value[11:0];
      REG_HEATWAVE:   thr_heatwave   = value[11:0];
      REG_LOCKOUT:    thr_lockout    = value[11:0];
      REG_CDEF_START: thr_cdef_start = value[11:0];
      REG_CDEF_END:   thr_cdef_end   = value[11:0];
      REG_ELEC_SEL:   thr_elec_sel   = value[11:0];
      REG_HDEF_END:   thr_hdef_end   = value[11:0];
      REG_HW_DELTA:   thr_hw_delta   = value[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Waits until the block has drained, then idles for pipeline slack.
  task automatic drain_block();
    while (pending_ticks.size() != 0 || expected_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [11:0] rand_temp();
    case ($urandom_range(0, 5))
      0: return -12'sd2048;
      1: return 12'sd2047;
      default: return 12'(signed'($urandom_range(0, 960)) - 320);
    endcase
  endfunction

  // Queues one tick; the stream clock advances by a jittered step.
  function automatic void queue_tick(logic [31:0] step, logic signed [11:0] oair,
                                     logic signed [11:0] unit, logic signed [11:0] ocoil,
                                     logic signed [11:0] iret, logic signed [11:0] icoil,
                                     logic call);
    tick_s t;
    clock_us = clock_us + step;
    t.now_us = clock_us;
    t.oair = oair; t.unit = unit; t.ocoil = ocoil;
    t.iret = iret; t.icoil = icoil; t.call = call;
    pending_ticks.insert(pending_ticks.size(), t);
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 9))
      0:       return $urandom;                       // wild jump, wraps the timestamp
      1, 2:    return $urandom_range(0, 300000);     // fine steps around the idle timeout
      default: return $urandom_range(200000, 6000000);
    endcase
  endfunction

  // A well-formed run: a held outdoor temperature, mostly steady call and coil
  // conditions, long enough steps to walk the delays and defrost phases.
  function automatic void queue_session(int n);
    logic signed [11:0] oair, unit, ocoil, iret, icoil;
    logic call;
    oair = rand_temp();
    unit = rand_temp();
    iret = rand_temp();
    for (int i = 0; i < n; i++) begin
      call  = ($urandom_range(0, 9) != 0);
      icoil = ($urandom_range(0, 3) == 0) ? rand_temp() : 12'sd400;
      ocoil = ($urandom_range(0, 4) == 0) ? rand_temp() : -12'sd100;
      if ($urandom_range(0, 11) == 0) unit = rand_temp();
      if ($urandom_range(0, 11) == 0) iret = rand_temp();
      queue_tick(rand_step(), oair, unit, ocoil, iret, icoil, call);
    end
  endfunction

  function automatic void queue_noise(int n);
    for (int i = 0; i < n; i++) begin
      queue_tick($urandom, 12'($urandom), 12'($urandom), 12'($urandom),
                 12'($urandom), 12'($urandom), 1'($urandom));
    end
  endfunction

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    allow_idle  = 1'b1;
    long_hold   = 1'b0;
    in_taken    = 1'b0;
    error_count = 0;
    quiet_cycles = 0;
    clock_us    = '0;
    restore_defaults();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the reset thresholds: heating with a full run into
    // reverse-cycle defrost, invalid outdoor air, wait timeout, cooling with a
    // coil defrost and heatwave entry with the season relay held.
    queue_tick(32'd10, -12'sd2048, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b1);
    queue_tick(32'd10, -12'sd2048, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b1);
    queue_tick(32'd2000000, 12'sd0, -12'sd2048, 12'sd0, 12'sd2047, 12'sd2047, 1'b1);
    queue_tick(32'd20000000, 12'sd0, -12'sd2048, 12'sd0, 12'sd0, 12'sd600, 1'b1);
    queue_tick(32'd10, 12'sd0, -12'sd2048, 12'sd0, 12'sd0, 12'sd0, 1'b1);
    queue_tick(32'd1500000, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0);
    queue_tick(32'd1500000, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0);
    queue_tick(32'd10, 12'sd0, 12'sd0, 12'sd2047, 12'sd0, 12'sd0, 1'b0);
    queue_tick(32'd5000000, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0);
    queue_tick(32'd3000000, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0);
    queue_tick(32'd10, 12'sd300, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0);
    queue_tick(32'd199999, 12'sd300, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0);
    queue_tick(32'd1, 12'sd300, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0);
    queue_tick(32'd10, 12'sd300, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0);
    queue_tick(32'd10, 12'sd300, 12'sd2047, 12'sd0, 12'sd2047, 12'sd400, 1'b1);
    queue_tick(32'd1000000, 12'sd300, 12'sd2047, 12'sd0, 12'sd2047, 12'sd400, 1'b1);
    queue_tick(32'd2000000, 12'sd300, 12'sd0, 12'sd0, 12'sd0, 12'sd400, 1'b1);
    queue_tick(32'd10, 12'sd300, 12'sd0, 12'sd0, 12'sd0, -12'sd2048, 1'b1);
    queue_tick(32'd10, 12'sd300, 12'sd0, 12'sd0, 12'sd0, 12'sd2047, 1'b0);
    queue_tick(32'd5000000, 12'sd300, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0);
    queue_tick(32'd3000000, 12'sd2047, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0);
    queue_tick(32'd10, 12'sd2047, 12'sd0, 12'sd0, 12'sd2047, 12'sd400, 1'b0);
    queue_tick(32'd1000000, 12'sd2047, 12'sd0, 12'sd0, 12'sd2047, 12'sd400, 1'b0);
    queue_tick(32'd2000000, 12'sd2047, 12'sd0, 12'sd0, 12'sd2047, 12'sd400, 1'b0);
    queue_tick(32'd10, 12'sd2047, 12'sd0, 12'sd0, -12'sd2048, 12'sd400, 1'b0);
    drain_block();

    // Random phases, each under its own set of thresholds; extremes included.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: for (int r = 0; r < 7; r++) write_threshold(reg_idx_t'(r), 32'h800);
        1: for (int r = 0; r < 7; r++) write_threshold(reg_idx_t'(r), 32'h7FF);
        default: for (int r = 0; r < 7; r++)
                   write_threshold(reg_idx_t'(r), 32'($urandom_range(0, 960) - 320));
      endcase
      write_threshold(REG_HW_DELTA, (phase == 0) ? 32'h0 : (phase == 1) ? 32'h7FF
                                    : 32'($urandom_range(0, 400)));
      for (int s = 0; s < 7; s++) queue_session($urandom_range(8, 16));
      queue_noise(10);
      if (phase == 3) begin
        // The receiver holds off for a long stretch while items keep coming.
        long_hold = 1'b1;
      end
      if (phase == 6) allow_idle = 1'b0;
      drain_block();
    end

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
